@@ hw/rtl/gji_pkg.sv @@
package gji_pkg;

  // fixed data format
  localparam int DATA_W = 32;
  localparam int CFG_W  = 4;
  // wide intermediate, holds any rounded sum or quotient before saturation
  localparam int WIDE_W = 66;

  localparam logic [CFG_W-1:0] ORDER_RESET = 4'd8;

  localparam logic signed [WIDE_W-1:0] WIDE_MAX = WIDE_W'(64'sd2147483647);
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = WIDE_W'(-64'sd2147483648);

  // arithmetic unit operations
  typedef enum logic [1:0] {
    OP_ADD,
    OP_DIV,
    OP_SUB
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  // arithmetic unit states
  typedef enum logic [2:0] {
    A_IDLE,
    A_MAG,
    A_SUB,
    A_DIV,
    A_DRND,
    A_DSAT
  } alu_state_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_LOAD,
    S_CLR,
    S_PIV_RD,
    S_PIV_CHK,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_FAC_RD,
    S_FAC_CAP,
    S_E_RDS,
    S_E_RDD,
    S_E_GO,
    S_E_WAIT,
    S_NEXT,
    S_OUT_RD,
    S_OUT_CAP,
    S_OUT_HOLD
  } seq_state_t;

  // clamp a wide signed value to 32 bits signed
  function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > WIDE_MAX) begin
      r = WIDE_MAX[DATA_W-1:0];
    end else if (v < WIDE_MIN) begin
      r = WIDE_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/gauss_jordan_matrix_inverse_unit.sv @@
// Gauss-Jordan matrix inverter, signed Q16.16.
// Write matrix_order (1..MAX_ORDER, 0 acts as 1, larger values as MAX_ORDER)
// with matrix_order_we while idle; a write restarts loading at the first entry.
// Entries enter on the in channel in row-major order, one per cycle while
// in_ready is high. After the last entry in_ready drops until the whole
// inverse has left on the out channel: n*n requests, row-major, result_last
// on the final one, singular constant over all of them.
// After the last entry the whole inverse store is first swept back to
// identity, then elimination runs. Every row operation runs element by
// element through one shared arithmetic unit: each element reads the source
// and destination entries, then adds (zero pivot), multiply-subtracts
// (clearing passes) or divides (pivot scaling), over both matrices.
// Each result is read from the inverse store and registered before out_valid
// rises; a stalled receiver simply holds the block, the result stays on the port until taken.
// Synchronous reset returns the block to loading with order 8 and clears
// the singular flag.
module gauss_jordan_matrix_inverse_unit #(
  parameter int MAX_ORDER = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              matrix_order_we,
  input  logic [gji_pkg::CFG_W-1:0]         matrix_order,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [gji_pkg::DATA_W-1:0] entry_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [gji_pkg::DATA_W-1:0] result_value,
  output logic                              result_last,
  output logic                              singular
);

  localparam int DW    = gji_pkg::DATA_W;
  localparam int RB    = $clog2(MAX_ORDER);
  localparam int CW    = $clog2(MAX_ORDER + 1);
  localparam int AW    = 2 * RB;
  localparam int DEPTH = 1 << AW;
  localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return {r[RB-1:0], c[RB-1:0]};
  endfunction

  gji_pkg::seq_state_t state, state_next;

  logic [gji_pkg::CFG_W-1:0] ord;
  logic [CW-1:0] n_use, nm1;

  logic [CW-1:0] lr, lr_next, lc, lc_next;
  logic [CW-1:0] row_i, row_i_next, row_j, row_j_next, col, col_next;
  logic [CW-1:0] dst, dst_next, src, src_next;
  logic          sel, sel_next;
  logic          sing, sing_next;
  gji_pkg::alu_op_t kind, kind_next;
  logic signed [DW-1:0] kreg, kreg_next, opa, opa_next;
  logic [AW-1:0] sweep, sweep_next;
  logic signed [DW-1:0] res_q;

  // memory ports
  logic          w_we, v_we;
  logic [AW-1:0] w_wa, w_ra, v_wa, v_ra;
  logic [DW-1:0] w_wd, v_wd, w_rd, v_rd;
  logic signed [DW-1:0] mrd;

  gji_pkg::alu_req_t    alu_req;
  logic                 alu_done;
  logic signed [DW-1:0] alu_res;

  gji_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_work (
    .clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd)
  );

  gji_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_inv (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd)
  );

  gji_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk(clk), .rst(rst), .req(alu_req), .x(mrd), .y(opa), .k(kreg),
    .done(alu_done), .res(alu_res)
  );

  // order in use
  always_comb begin
    if (ord == '0) begin
      n_use = CW'(1);
    end else if (ord > gji_pkg::CFG_W'(MAX_ORDER)) begin
      n_use = CW'(MAX_ORDER);
    end else begin
      n_use = CW'(ord);
    end
    nm1 = n_use - CW'(1);
    mrd = sel ? $signed(v_rd) : $signed(w_rd);
  end

  // port outputs
  assign in_ready     = (state == gji_pkg::S_LOAD);
  assign out_valid    = (state == gji_pkg::S_OUT_HOLD);
  assign result_value = res_q;
  assign result_last  = (lr == nm1) && (lc == nm1);
  assign singular     = sing;

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gji_pkg::S_LOAD;
      ord   <= gji_pkg::ORDER_RESET;
      lr    <= '0;
      lc    <= '0;
      sing  <= 1'b0;
    end else begin
      state <= state_next;
      if (matrix_order_we) begin
        ord <= matrix_order;
      end
      lr    <= lr_next;
      lc    <= lc_next;
      sing  <= sing_next;
    end
  end

  // sequencer working registers
  always_ff @(posedge clk) begin
    row_i <= row_i_next;
    row_j <= row_j_next;
    col   <= col_next;
    dst   <= dst_next;
    src   <= src_next;
    sel   <= sel_next;
    kind  <= kind_next;
    kreg  <= kreg_next;
    opa   <= opa_next;
    sweep <= sweep_next;
    if (state == gji_pkg::S_OUT_CAP) begin
      res_q <= $signed(v_rd);
    end
  end

  // next state, counters and memory control
  always_comb begin
    state_next = state;
    lr_next    = lr;
    lc_next    = lc;
    row_i_next = row_i;
    row_j_next = row_j;
    col_next   = col;
    dst_next   = dst;
    src_next   = src;
    sel_next   = sel;
    sing_next  = sing;
    kind_next  = kind;
    kreg_next  = kreg;
    opa_next   = opa;
    sweep_next = sweep;
    w_we = 1'b0; w_wa = '0; w_wd = '0; w_ra = '0;
    v_we = 1'b0; v_wa = '0; v_wd = '0; v_ra = '0;
    alu_req.start = 1'b0;
    alu_req.op    = kind;

    unique case (state)
      // take entries row-major
      gji_pkg::S_LOAD: begin
        if (matrix_order_we) begin
          lr_next = '0;
          lc_next = '0;
        end else if (in_valid) begin
          w_we = 1'b1;
          w_wa = addr_of(lr, lc);
          w_wd = entry_value;
          if (lc == nm1) begin
            lc_next = '0;
            if (lr == nm1) begin
              lr_next    = '0;
              sweep_next = '0;
              sing_next  = 1'b0;
              state_next = gji_pkg::S_CLR;
            end else begin
              lr_next = lr + CW'(1);
            end
          end else begin
            lc_next = lc + CW'(1);
          end
        end
      end
      // inverse store back to identity
      gji_pkg::S_CLR: begin
        v_we = 1'b1;
        v_wa = sweep;
        v_wd = (sweep[AW-1:RB] == sweep[RB-1:0]) ? ONE : '0;
        sweep_next = sweep + AW'(1);
        if (sweep == AW'(DEPTH - 1)) begin
          row_i_next = '0;
          state_next = gji_pkg::S_PIV_RD;
        end
      end
      gji_pkg::S_PIV_RD: begin
        w_ra = addr_of(row_i, row_i);
        state_next = gji_pkg::S_PIV_CHK;
      end
      gji_pkg::S_PIV_CHK: begin
        if (w_rd != '0) begin
          kreg_next  = $signed(w_rd);
          kind_next  = gji_pkg::OP_DIV;
          dst_next   = row_i;
          src_next   = row_i;
          col_next   = '0;
          sel_next   = 1'b0;
          state_next = gji_pkg::S_E_RDS;
        end else begin
          row_j_next = row_i + CW'(1);
          state_next = gji_pkg::S_SRCH_RD;
        end
      end
      // zero pivot: look below for a nonzero entry
      gji_pkg::S_SRCH_RD: begin
        if (row_j >= n_use) begin
          sing_next  = 1'b1;
          state_next = gji_pkg::S_NEXT;
        end else begin
          w_ra = addr_of(row_j, row_i);
          state_next = gji_pkg::S_SRCH_CHK;
        end
      end
      gji_pkg::S_SRCH_CHK: begin
        if (w_rd != '0) begin
          kind_next  = gji_pkg::OP_ADD;
          dst_next   = row_i;
          src_next   = row_j;
          col_next   = '0;
          sel_next   = 1'b0;
          state_next = gji_pkg::S_E_RDS;
        end else begin
          row_j_next = row_j + CW'(1);
          state_next = gji_pkg::S_SRCH_RD;
        end
      end
      // factor of each other row
      gji_pkg::S_FAC_RD: begin
        if (row_j >= n_use) begin
          state_next = gji_pkg::S_NEXT;
        end else if (row_j == row_i) begin
          row_j_next = row_j + CW'(1);
        end else begin
          w_ra = addr_of(row_j, row_i);
          state_next = gji_pkg::S_FAC_CAP;
        end
      end
      gji_pkg::S_FAC_CAP: begin
        kreg_next  = $signed(w_rd);
        kind_next  = gji_pkg::OP_SUB;
        dst_next   = row_j;
        src_next   = row_i;
        col_next   = '0;
        sel_next   = 1'b0;
        state_next = gji_pkg::S_E_RDS;
      end
      // element loop: working matrix, then inverse
      gji_pkg::S_E_RDS: begin
        w_ra = addr_of(src, col);
        v_ra = addr_of(src, col);
        state_next = gji_pkg::S_E_RDD;
      end
      gji_pkg::S_E_RDD: begin
        opa_next = mrd;
        w_ra = addr_of(dst, col);
        v_ra = addr_of(dst, col);
        state_next = gji_pkg::S_E_GO;
      end
      gji_pkg::S_E_GO: begin
        alu_req.start = 1'b1;
        state_next = gji_pkg::S_E_WAIT;
      end
      gji_pkg::S_E_WAIT: begin
        if (alu_done) begin
          if (sel) begin
            v_we = 1'b1;
            v_wa = addr_of(dst, col);
            v_wd = alu_res;
          end else begin
            w_we = 1'b1;
            w_wa = addr_of(dst, col);
            w_wd = alu_res;
          end
          state_next = gji_pkg::S_E_RDS;
          if (col == nm1) begin
            col_next = '0;
            if (!sel) begin
              sel_next = 1'b1;
            end else begin
              case (kind)
                gji_pkg::OP_ADD: state_next = gji_pkg::S_PIV_RD;
                gji_pkg::OP_DIV: begin
                  row_j_next = '0;
                  state_next = gji_pkg::S_FAC_RD;
                end
                default: begin
                  row_j_next = row_j + CW'(1);
                  state_next = gji_pkg::S_FAC_RD;
                end
              endcase
            end
          end else begin
            col_next = col + CW'(1);
          end
        end
      end
      gji_pkg::S_NEXT: begin
        if (row_i == nm1) begin
          lr_next    = '0;
          lc_next    = '0;
          state_next = gji_pkg::S_OUT_RD;
        end else begin
          row_i_next = row_i + CW'(1);
          state_next = gji_pkg::S_PIV_RD;
        end
      end
      // stream the inverse
      gji_pkg::S_OUT_RD: begin
        v_ra = addr_of(lr, lc);
        state_next = gji_pkg::S_OUT_CAP;
      end
      gji_pkg::S_OUT_CAP: begin
        state_next = gji_pkg::S_OUT_HOLD;
      end
      gji_pkg::S_OUT_HOLD: begin
        if (out_ready) begin
          state_next = gji_pkg::S_OUT_RD;
          if (lc == nm1) begin
            lc_next = '0;
            if (lr == nm1) begin
              lr_next    = '0;
              state_next = gji_pkg::S_LOAD;
            end else begin
              lr_next = lr + CW'(1);
            end
          end else begin
            lc_next = lc + CW'(1);
          end
        end
      end
      default: state_next = gji_pkg::S_LOAD;
    endcase
  end

endmodule

@@ hw/rtl/gji_ram.sv @@
module gji_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/gji_alu.sv @@
module gji_alu #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gji_pkg::alu_req_t                   req,
  input  logic signed [gji_pkg::DATA_W-1:0]   x,
  input  logic signed [gji_pkg::DATA_W-1:0]   y,
  input  logic signed [gji_pkg::DATA_W-1:0]   k,
  output logic                                done,
  output logic signed [gji_pkg::DATA_W-1:0]   res
);

  localparam int DW   = gji_pkg::DATA_W;
  localparam int WW   = gji_pkg::WIDE_W;
  localparam int NW   = DW + FRAC_BITS;
  localparam int CNTW = $clog2(NW + 1);

  gji_pkg::alu_state_t ast, ast_next;

  logic signed [DW-1:0]   x_q;
  logic                   neg_q;
  logic signed [2*DW-1:0] prod_q;
  logic [2*DW-1:0]        sq_q;
  logic [DW-1:0]          rem_q;
  logic [DW-1:0]          den_q;
  logic [NW-1:0]          num_q;
  logic [NW-1:0]          quo_q;
  logic [CNTW-1:0]        cnt;

  logic [2*DW-1:0]        prod_mag;
  logic signed [WW-1:0]   sq_wide;
  logic signed [WW-1:0]   x_wide;
  logic signed [WW-1:0]   sub_wide;
  logic signed [WW-1:0]   div_wide;
  logic signed [WW-1:0]   add_wide;
  logic [DW:0]            trial;
  logic                   ge;
  logic                   round_up;
  logic [DW-1:0]          absx;
  logic [DW-1:0]          absk;

  always_comb begin
    prod_mag = prod_q[2*DW-1] ? (2*DW)'(-prod_q) : (2*DW)'(prod_q);
    sq_wide  = $signed({2'b00, sq_q});
    x_wide   = WW'(x_q);
    sub_wide = neg_q ? (x_wide + sq_wide) : (x_wide - sq_wide);
    div_wide = neg_q ? -sq_wide : sq_wide;
    add_wide = WW'(x) + WW'(y);
    trial    = {rem_q, num_q[NW-1]};
    ge       = (trial >= {1'b0, den_q});
    round_up = ({rem_q, 1'b0} >= {1'b0, den_q});
    absx     = x[DW-1] ? DW'(-x) : DW'(x);
    absk     = k[DW-1] ? DW'(-k) : DW'(k);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      ast <= gji_pkg::A_IDLE;
    end else begin
      ast <= ast_next;
    end
  end

  // next state
  always_comb begin
    ast_next = ast;
    unique case (ast)
      gji_pkg::A_IDLE: begin
        if (req.start) begin
          case (req.op)
            gji_pkg::OP_SUB: ast_next = gji_pkg::A_MAG;
            gji_pkg::OP_DIV: ast_next = gji_pkg::A_DIV;
            default:         ast_next = gji_pkg::A_IDLE;
          endcase
        end
      end
      gji_pkg::A_MAG:  ast_next = gji_pkg::A_SUB;
      gji_pkg::A_SUB:  ast_next = gji_pkg::A_IDLE;
      gji_pkg::A_DIV:  ast_next = (cnt == CNTW'(1)) ? gji_pkg::A_DRND : gji_pkg::A_DIV;
      gji_pkg::A_DRND: ast_next = gji_pkg::A_DSAT;
      gji_pkg::A_DSAT: ast_next = gji_pkg::A_IDLE;
      default:         ast_next = gji_pkg::A_IDLE;
    endcase
  end

  // done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((ast == gji_pkg::A_IDLE) && req.start && (req.op == gji_pkg::OP_ADD)) ||
              (ast == gji_pkg::A_SUB) || (ast == gji_pkg::A_DSAT);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (ast)
      gji_pkg::A_IDLE: begin
        if (req.start) begin
          case (req.op)
            gji_pkg::OP_ADD: res <= gji_pkg::sat_wide(add_wide);
            gji_pkg::OP_SUB: begin
              prod_q <= y * k;
              x_q    <= x;
            end
            default: begin
              neg_q <= x[DW-1] ^ k[DW-1];
              num_q <= {absx, {FRAC_BITS{1'b0}}};
              den_q <= absk;
              rem_q <= '0;
              quo_q <= '0;
              cnt   <= CNTW'(NW);
            end
          endcase
        end
      end
      // magnitude, round half away from zero at the binary point
      gji_pkg::A_MAG: begin
        neg_q <= prod_q[2*DW-1];
        sq_q  <= (prod_mag >> FRAC_BITS) + (2*DW)'(prod_mag[FRAC_BITS-1]);
      end
      gji_pkg::A_SUB: res <= gji_pkg::sat_wide(sub_wide);
      // restoring division, one quotient bit per cycle
      gji_pkg::A_DIV: begin
        rem_q <= ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
        quo_q <= {quo_q[NW-2:0], ge};
        num_q <= num_q << 1;
        cnt   <= cnt - CNTW'(1);
      end
      gji_pkg::A_DRND: sq_q <= (2*DW)'(quo_q) + (2*DW)'(round_up);
      gji_pkg::A_DSAT: res <= gji_pkg::sat_wide(div_wide);
      default: ;
    endcase
  end

endmodule
